### rtl/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg
// shared types and constants of the sparse matrix-vector multiply block
// ----------------------------------------------------------------------------
package spmv_pkg;

  // payload widths fixed by the item format
  localparam int KIND_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int Y_W       = 48;
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int DEFAULT_MAX_DIM   = 1024;
  localparam int DEFAULT_FRAC_BITS = 16;
  localparam int DEFAULT_IDX_W     = $clog2(DEFAULT_MAX_DIM);

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_READ    = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STORAGE_ORDER = 2'd0,
    REG_ROW_COUNT     = 2'd1,
    REG_COL_COUNT     = 2'd2
  } cfg_reg_t;

endpackage

### rtl/spmv_in_if.sv
// ----------------------------------------------------------------------------
// spmv_in_if
// request channel: load, nonzero or read-and-clear items
// ----------------------------------------------------------------------------
interface spmv_in_if #(
  parameter int IDX_W = spmv_pkg::DEFAULT_IDX_W
);
  logic                                valid;
  logic                                ready;
  logic [spmv_pkg::KIND_W-1:0]         kind;
  logic [IDX_W-1:0]                    vector_index;
  logic [IDX_W-1:0]                    line_index;
  logic [IDX_W-1:0]                    entry_index;
  logic signed [spmv_pkg::VALUE_W-1:0] value;

  modport source (
    output valid, kind, vector_index, line_index, entry_index, value,
    input  ready
  );

  modport sink (
    input  valid, kind, vector_index, line_index, entry_index, value,
    output ready
  );
endinterface

### rtl/spmv_out_if.sv
// ----------------------------------------------------------------------------
// spmv_out_if
// result channel: one result per request
// ----------------------------------------------------------------------------
interface spmv_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [spmv_pkg::Y_W-1:0] result_value;
  logic                            error;

  modport source (
    output valid, result_value, error,
    input  ready
  );

  modport sink (
    input  valid, result_value, error,
    output ready
  );
endinterface

### rtl/sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// streamed sparse matrix times dense vector, Q16.16 in, Q32.16 sums
// ----------------------------------------------------------------------------
// usage
//   in_chan  : requests, one per cycle at most. kind load writes x[vector_index],
//              kind nonzero adds (value * x[col]) >> FRAC_BITS into y[row] with
//              48-bit saturation, kind read returns y[vector_index] and clears it.
//              row/col come from line_index/entry_index per storage_order.
//   out_chan : exactly one result per request, in request order. result_value
//              is the updated sum (nonzero), the old y element (read), else 0.
//              error flags an index at or beyond the configured count; such a
//              request changes no state and returns 0.
//   cfg_*    : register writes (storage order, row count, col count), only
//              while the block is idle.
// timing
//   each request passes stage b, stage c and the output register before its
//   result is valid. throughput one request per cycle while no result is
//   stalled and no clearing pass runs: x and y are single-port-read memories,
//   the y read-modify-write is covered by forwarding from the write-back stage.
// reset
//   synchronous, active low. after reset a clearing pass writes zero to each
//   y entry; in_chan.ready stays low meanwhile. x is not cleared; reading an
//   unloaded x element gives an undefined product.
// stall
//   when out_chan.ready is low with a result waiting, the whole pipeline
//   holds and in_chan.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply #(
  parameter int MAX_DIM   = spmv_pkg::DEFAULT_MAX_DIM,
  parameter int FRAC_BITS = spmv_pkg::DEFAULT_FRAC_BITS,
  parameter int IDX_W     = $clog2(MAX_DIM),
  parameter int CNT_W     = $clog2(MAX_DIM + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  spmv_in_if.sink                         in_chan,
  spmv_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [spmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]                cfg_data
);

  localparam int VALUE_W = spmv_pkg::VALUE_W;
  localparam int Y_W     = spmv_pkg::Y_W;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_DIM);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIM - 1);
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  // configuration registers
  logic             order_r;
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] col_count_r;

  // clearing pass over y
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_addr_r;

  // memories
  logic signed [VALUE_W-1:0] x_mem [MAX_DIM];
  logic signed [Y_W-1:0]     y_mem [MAX_DIM];

  // stage b: memory read data
  logic                      b_valid_r;
  logic [spmv_pkg::KIND_W-1:0] b_kind_r;
  logic                      b_err_r;
  logic [IDX_W-1:0]          b_yaddr_r;
  logic signed [VALUE_W-1:0] b_value_r;
  logic signed [VALUE_W-1:0] x_rd_r;
  logic signed [Y_W-1:0]     y_rd_r;
  logic                      y_hit_r;
  logic signed [Y_W-1:0]     y_byp_r;

  // stage c: product and forwarded sum
  logic                      c_valid_r;
  logic [spmv_pkg::KIND_W-1:0] c_kind_r;
  logic                      c_err_r;
  logic [IDX_W-1:0]          c_yaddr_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [Y_W-1:0]     y_c_r;

  // output register
  logic                      out_valid_r;
  logic signed [Y_W-1:0]     out_value_r;
  logic                      out_err_r;

  // handshake
  logic adv;
  logic in_acc;

  assign adv              = !out_valid_r || out_chan.ready;
  assign in_chan.ready    = adv && !clr_busy_r;
  assign in_acc           = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.error        = out_err_r;

  // ---------------------------------------------------------------- stage a
  // index decode and range checks on the incoming request
  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  logic [IDX_W-1:0] in_yaddr;
  logic             row_ok;
  logic             col_ok;
  logic             vrow_ok;
  logic             vcol_ok;
  logic             in_err;
  logic             x_we;

  assign in_row  = order_r ? in_chan.entry_index : in_chan.line_index;
  assign in_col  = order_r ? in_chan.line_index  : in_chan.entry_index;
  assign row_ok  = (CNT_W'(in_row) < row_count_r) && (CNT_W'(in_row) < MAX_CNT);
  assign col_ok  = (CNT_W'(in_col) < col_count_r) && (CNT_W'(in_col) < MAX_CNT);
  assign vrow_ok = (CNT_W'(in_chan.vector_index) < row_count_r)
                && (CNT_W'(in_chan.vector_index) < MAX_CNT);
  assign vcol_ok = (CNT_W'(in_chan.vector_index) < col_count_r)
                && (CNT_W'(in_chan.vector_index) < MAX_CNT);

  always_comb begin
    in_err   = 1'b0;
    in_yaddr = in_row;
    case (in_chan.kind)
      spmv_pkg::KIND_LOAD:    in_err = !vcol_ok;
      spmv_pkg::KIND_NONZERO: in_err = !(row_ok && col_ok);
      spmv_pkg::KIND_READ: begin
        in_err   = !vrow_ok;
        in_yaddr = in_chan.vector_index;
      end
      default: in_err = 1'b0;
    endcase
  end

  // loads write x on the accept edge, so a nonzero right behind sees it
  assign x_we = in_acc && (in_chan.kind == spmv_pkg::KIND_LOAD) && !in_err;

  // ---------------------------------------------------------------- stage c
  // shift, accumulate, saturate, write back
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum_wide;
  logic signed [Y_W-1:0]    sum_sat;
  logic signed [Y_W-1:0]    c_wdata;
  logic signed [Y_W-1:0]    c_result;
  logic                     c_we;
  logic                     y_we;
  logic [IDX_W-1:0]         y_waddr;
  logic signed [Y_W-1:0]    y_wdata;
  logic signed [Y_W-1:0]    y_b;

  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign sum_wide = SUM_W'(y_c_r) + SUM_W'(prod_sh);

  // overflow when the bits above the 48-bit sign are not a sign extension
  always_comb begin
    if ((&sum_wide[SUM_W-1:Y_W-1]) || !(|sum_wide[SUM_W-1:Y_W-1])) begin
      sum_sat = sum_wide[Y_W-1:0];
    end else if (sum_wide[SUM_W-1]) begin
      sum_sat = Y_MIN;
    end else begin
      sum_sat = Y_MAX;
    end
  end

  always_comb begin
    c_we     = 1'b0;
    c_wdata  = '0;
    c_result = '0;
    case (c_kind_r)
      spmv_pkg::KIND_NONZERO: begin
        c_we     = !c_err_r;
        c_wdata  = sum_sat;
        c_result = c_err_r ? '0 : sum_sat;
      end
      spmv_pkg::KIND_READ: begin
        c_we     = !c_err_r;
        c_wdata  = '0;
        c_result = c_err_r ? '0 : y_c_r;
      end
      default: c_we = 1'b0;
    endcase
    c_we = c_we && c_valid_r && adv;
  end

  // single y write port: clearing pass or write-back
  assign y_we    = clr_busy_r || c_we;
  assign y_waddr = clr_busy_r ? clr_addr_r : c_yaddr_r;
  assign y_wdata = clr_busy_r ? '0 : c_wdata;

  // y seen by stage b, with the write-back from the accept edge folded in
  assign y_b = y_hit_r ? y_byp_r : y_rd_r;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[in_chan.vector_index] <= in_chan.value;
    end
    if (adv) begin
      x_rd_r <= x_mem[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[y_waddr] <= y_wdata;
    end
    if (adv) begin
      y_rd_r <= y_mem[in_yaddr];
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= 1'b0;
      row_count_r <= MAX_CNT;
      col_count_r <= MAX_CNT;
    end else if (cfg_we) begin
      case (cfg_index)
        spmv_pkg::REG_STORAGE_ORDER: order_r     <= cfg_data[0];
        spmv_pkg::REG_ROW_COUNT:     row_count_r <= cfg_data;
        spmv_pkg::REG_COL_COUNT:     col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- clearing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r   <= in_acc;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage b
      b_kind_r  <= in_chan.kind;
      b_err_r   <= in_err;
      b_yaddr_r <= in_yaddr;
      b_value_r <= in_chan.value;
      y_hit_r   <= c_we && (c_yaddr_r == in_yaddr);
      y_byp_r   <= c_wdata;
      // stage c
      c_kind_r  <= b_kind_r;
      c_err_r   <= b_err_r;
      c_yaddr_r <= b_yaddr_r;
      prod_r    <= PROD_W'(b_value_r) * PROD_W'(x_rd_r);
      y_c_r     <= (c_we && (c_yaddr_r == b_yaddr_r)) ? c_wdata : y_b;
      // output
      out_value_r <= c_result;
      out_err_r   <= c_err_r;
    end
  end

  // ---------------------------------------------------------------- checks
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !in_chan.ready
  ) else $error("request accepted during y clearing pass");

  a_no_writeback_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !c_valid_r && !b_valid_r
  ) else $error("pipeline active during y clearing pass");

  a_error_no_write: assert property (
    @(posedge clk) disable iff (!rst_n) (c_valid_r && c_err_r) |-> !c_we
  ) else $error("out-of-range request wrote y");

  a_stall_holds_pipe: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_chan.ready) |=> $stable(c_valid_r) && $stable(b_valid_r)
  ) else $error("pipeline moved while output stalled");

  a_clear_covers_all: assert property (
    @(posedge clk) disable iff (!rst_n)
      $fell(clr_busy_r) |-> $past(clr_addr_r) == LAST_IDX
  ) else $error("clearing pass ended early");

endmodule
